[hw/rtl/hkxc_pkg.sv]
// Package with shared constants, item codes and the key pad for the keyed XOR cipher.
`default_nettype none

package hkxc_pkg;

	localparam int unsigned HASH_W = 32;
	localparam int unsigned POS_W = 5;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned PAD_LEN = 32;

	localparam logic [HASH_W-1:0] HASH_INIT = 32'd5381;
	localparam logic [BYTE_W-1:0] SPREAD_STEP = 8'd7;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_KEY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t BASE_PAD [PAD_LEN] = '{
		8'h5A, 8'hA5, 8'h1F, 8'h2E, 8'h3D, 8'h4C, 8'h5B, 8'h6A,
		8'h79, 8'h88, 8'h97, 8'hA6, 8'hB5, 8'hC4, 8'hD3, 8'hE2,
		8'hF1, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
		8'h77, 8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE
	};

endpackage

`default_nettype wire

[hw/rtl/hkxc_keygen.sv]
// Key byte generator: pad byte mixed with one hash byte plus a position-dependent offset.
`default_nettype none

module hkxc_keygen
	import hkxc_pkg::*;
(
	input  wire logic [HASH_W-1:0] hash,
	input  wire logic [POS_W-1:0]  pos,
	output byte_t                  key_byte
);

	byte_t hash_byte;
	byte_t spread;

	always_comb begin
		case (pos[1:0])
			2'd0:    hash_byte = hash[7:0];
			2'd1:    hash_byte = hash[15:8];
			2'd2:    hash_byte = hash[23:16];
			2'd3:    hash_byte = hash[31:24];
			default: hash_byte = hash[7:0];
		endcase
	end

	assign spread = byte_t'(SPREAD_STEP * byte_t'(pos));
	assign key_byte = byte_t'((BASE_PAD[pos] ^ hash_byte) + spread);

endmodule

`default_nettype wire

[hw/rtl/hash_keyed_repeating_xor_cipher.sv]
// Top level of the hash-keyed repeating XOR byte cipher.
//
// Channel | Signals                         | Direction | Word
// input   | in_valid, in_ready, kind, value | in        | start, key byte or data byte
// output  | out_valid, out_ready, out_byte  | out       | ciphered data byte
//
// One word is accepted per cycle unless a data word waits on a stalled output; data words then reach the output.
// The input register feeds the hash and key logic, whose result lands in the output register.
// Reset sets the hash to 5381 and the data position to 0, as a start word does.
// A stalled output holds only data words in the input register; start and key words pass on.
`default_nettype none

module hash_keyed_repeating_xor_cipher
	import hkxc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [BYTE_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      out_byte
);

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	byte_t             value_s1;
	logic [HASH_W-1:0] hash_q;
	logic [POS_W-1:0]  pos_q;
	logic              out_valid_q;
	byte_t             out_byte_q;
	byte_t             key_byte;
	logic              out_free;
	logic              is_data_s1;
	logic              go_s1;

	hkxc_keygen u_keygen (
		.hash     (hash_q),
		.pos      (pos_q),
		.key_byte (key_byte)
	);

	assign out_free = !out_valid_q || out_ready;
	assign is_data_s1 = (kind_s1 == KIND_DATA);
	assign go_s1 = valid_s1 && (!is_data_s1 || out_free);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			value_s1 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_INIT;
			pos_q <= '0;
		end else if (go_s1) begin
			case (kind_s1)
				KIND_START: begin
					hash_q <= HASH_INIT;
					pos_q <= '0;
				end
				KIND_KEY: begin
					hash_q <= (hash_q << 5) + hash_q + HASH_W'(value_s1);
				end
				KIND_DATA: begin
					pos_q <= pos_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_data_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_data_s1) begin
			out_byte_q <= value_s1 ^ key_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;

endmodule

`default_nettype wire

[hw/rtl/hkxc_checker.sv]
// Port-level checker for the cipher top level and the bind that attaches it.
`default_nettype none

module hkxc_checker
	import hkxc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [KIND_W-1:0] kind,
	input wire logic [BYTE_W-1:0] value,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [BYTE_W-1:0] out_byte
);

	// A stalled output word must hold its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output word changed while stalled");

	// The input only backs up behind a stalled output word.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// A fresh output word comes from an accepted data word that passed through the input register.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_DATA), 2))
		else $error("output word without an accepted data word");

	// The handshake outputs in_ready and out_valid are always known, and an offered word carries known fields.
	a_no_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}) && (!in_valid || !$isunknown({kind, value})))
		else $error("unknown value on a handshake or an offered word");

endmodule

bind hash_keyed_repeating_xor_cipher hkxc_checker u_hkxc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.value     (value),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte)
);

`default_nettype wire
